>>> rtl/hcte_pkg.sv
package hcte_pkg;

  localparam int unsigned SymbolCountDef = 256;
  localparam int unsigned MaxCodeBitsDef = 32;

  localparam int unsigned OpW     = 2;
  localparam int unsigned SymbolW = 8;
  localparam int unsigned CodeInW = 32;
  localparam int unsigned LenInW  = 6;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned PendW   = 7;
  localparam int unsigned CntW    = 3;

  typedef enum logic [OpW-1:0] {
    OP_WRITE  = 2'd0,
    OP_ENCODE = 2'd1,
    OP_FLUSH  = 2'd2
  } op_e;

  // controller -> datapath
  typedef struct packed {
    logic write_entry;  // load table entry from the input ports
    logic lookup;       // register symbol check and table read
    logic load;         // move looked-up code into the shifter
    logic step;         // pack up to one byte worth of code bits
    logic emit_error;   // present the missing-entry result
    logic flush;        // present the padded partial byte
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;     // output register can take a result this cycle
    logic entry_ok;     // looked-up symbol has a valid entry
    logic pend_empty;   // no bits waiting in the packer
    logic step_done;    // current step consumes the remaining code bits
  } status_t;

endpackage

>>> rtl/huffman_code_table_encoder.sv
// Huffman code table encoder with an MSB-first byte packer. op WRITE loads one
// table entry (code, length 1..MAX_CODE_BITS, longer lengths saturate, length 0
// invalidates). op ENCODE accepts the symbol and reads the table (registered
// memory read), then loads the code into the shifter, then does one packing
// step per cycle while the output register can take a result, each moving up
// to one byte worth of code bits. That is 1 to 5 steps. Every step that
// completes a byte produces one output byte. A missing entry gives a single
// result with error set. op FLUSH emits the zero-padded partial byte or
// nothing when the packer is empty.
// One transaction is worked on at a time; the input is ready whenever the
// controller is idle, even while the last result still waits in the output
// register. Packing steps stall while the output register holds an untaken
// result. All valid marks are cleared by reset; no clearing pass is needed.
module huffman_code_table_encoder #(
  parameter int unsigned SYMBOL_COUNT  = hcte_pkg::SymbolCountDef,
  parameter int unsigned MAX_CODE_BITS = hcte_pkg::MaxCodeBitsDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [hcte_pkg::OpW-1:0]         op_i,
  input  logic [hcte_pkg::SymbolW-1:0]     symbol_i,
  input  logic [hcte_pkg::CodeInW-1:0]     code_bits_i,
  input  logic [hcte_pkg::LenInW-1:0]      code_length_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [hcte_pkg::ByteW-1:0]       out_byte_o,
  output logic                             last_of_run_o,
  output logic                             error_o
);

  hcte_pkg::cmd_t    cmd;
  hcte_pkg::status_t status;

  hcte_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .op_i       (op_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  hcte_datapath #(
    .SYMBOL_COUNT  (SYMBOL_COUNT),
    .MAX_CODE_BITS (MAX_CODE_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .symbol_i      (symbol_i),
    .code_bits_i   (code_bits_i),
    .code_length_i (code_length_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_byte_o    (out_byte_o),
    .last_of_run_o (last_of_run_o),
    .error_o       (error_o)
  );

endmodule

>>> rtl/hcte_ctrl.sv
module hcte_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [hcte_pkg::OpW-1:0]     op_i,
  input  hcte_pkg::status_t            status_i,
  output hcte_pkg::cmd_t               cmd_o
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_LOOKUP = 5'b00010,
    ST_EMIT   = 5'b00100,
    ST_ERROR  = 5'b01000,
    ST_FLUSH  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          unique case (hcte_pkg::op_e'(op_i))
            hcte_pkg::OP_WRITE: begin
              cmd_o.write_entry = 1'b1;
            end
            hcte_pkg::OP_ENCODE: begin
              cmd_o.lookup = 1'b1;
              state_d      = ST_LOOKUP;
            end
            hcte_pkg::OP_FLUSH: begin
              if (!status_i.pend_empty) begin
                state_d = ST_FLUSH;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_LOOKUP: begin
        if (status_i.entry_ok) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EMIT;
        end else begin
          state_d = ST_ERROR;
        end
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.step = 1'b1;
          if (status_i.step_done) begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_ERROR: begin
        if (status_i.out_free) begin
          cmd_o.emit_error = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (status_i.out_free) begin
          cmd_o.flush = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> rtl/hcte_datapath.sv
module hcte_datapath #(
  parameter int unsigned SYMBOL_COUNT  = hcte_pkg::SymbolCountDef,
  parameter int unsigned MAX_CODE_BITS = hcte_pkg::MaxCodeBitsDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [hcte_pkg::SymbolW-1:0]     symbol_i,
  input  logic [hcte_pkg::CodeInW-1:0]     code_bits_i,
  input  logic [hcte_pkg::LenInW-1:0]      code_length_i,
  input  hcte_pkg::cmd_t                   cmd_i,
  output hcte_pkg::status_t                status_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [hcte_pkg::ByteW-1:0]       out_byte_o,
  output logic                             last_of_run_o,
  output logic                             error_o
);

  localparam int unsigned IdxW   = $clog2(SYMBOL_COUNT);
  localparam int unsigned LenW   = $clog2(MAX_CODE_BITS + 1);
  localparam int unsigned EntryW = MAX_CODE_BITS + LenW;

  // table: valid marks in flops, code and length in memory
  logic [SYMBOL_COUNT-1:0] valid_q;
  logic [EntryW-1:0]       table_q [SYMBOL_COUNT];
  logic [EntryW-1:0]       rd_q;
  logic                    entry_ok_q;

  logic [IdxW-1:0]          idx;
  logic                     sym_in_range;
  logic [LenW-1:0]          len_sat;
  logic                     len_zero;

  assign idx          = symbol_i[IdxW-1:0];
  assign sym_in_range = ({1'b0, symbol_i} < 9'(SYMBOL_COUNT));
  assign len_zero     = (code_length_i == '0);
  assign len_sat      = (code_length_i > hcte_pkg::LenInW'(MAX_CODE_BITS))
                        ? LenW'(MAX_CODE_BITS) : code_length_i[LenW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.write_entry && sym_in_range && !len_zero) begin
      table_q[idx] <= {code_bits_i[MAX_CODE_BITS-1:0], len_sat};
    end
    if (cmd_i.lookup) begin
      rd_q <= table_q[idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      entry_ok_q <= 1'b0;
    end else begin
      if (cmd_i.write_entry && sym_in_range) begin
        valid_q[idx] <= !len_zero;
      end
      if (cmd_i.lookup) begin
        entry_ok_q <= sym_in_range && valid_q[idx];
      end
    end
  end

  // code shifter and bit packer
  logic [MAX_CODE_BITS-1:0]        code_q;
  logic [LenW-1:0]                 rem_q;
  logic [hcte_pkg::PendW-1:0]      pend_q, pend_d;
  logic [hcte_pkg::CntW-1:0]       cnt_q, cnt_d;

  logic [3:0]                      space;
  logic [3:0]                      step_k;
  logic [3:0]                      cnt_sum;
  logic                            fill;
  logic [LenW-1:0]                 rem_after;
  logic [hcte_pkg::ByteW-1:0]      acc;
  logic [hcte_pkg::ByteW-1:0]      flush_byte;
  logic [3:0]                      flush_shift;

  assign space     = 4'd8 - {1'b0, cnt_q};
  assign step_k    = (7'(rem_q) < 7'(space)) ? 4'(rem_q) : space;
  assign cnt_sum   = {1'b0, cnt_q} + step_k;
  assign fill      = (cnt_sum == 4'd8);
  assign rem_after = rem_q - LenW'(step_k);

  // append code bits low index first; earliest bit ends up highest
  always_comb begin
    acc = {1'b0, pend_q};
    for (int i = 0; i < 8; i++) begin
      if (4'(i) < step_k) begin
        acc = {acc[6:0], code_q[i]};
      end
    end
  end

  assign flush_shift = 4'd8 - {1'b0, cnt_q};
  assign flush_byte  = {1'b0, pend_q} << flush_shift;

  always_comb begin
    pend_d = pend_q;
    cnt_d  = cnt_q;
    if (cmd_i.step) begin
      if (fill) begin
        pend_d = '0;
        cnt_d  = '0;
      end else begin
        pend_d = acc[hcte_pkg::PendW-1:0];
        cnt_d  = cnt_sum[hcte_pkg::CntW-1:0];
      end
    end else if (cmd_i.flush) begin
      pend_d = '0;
      cnt_d  = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      code_q <= rd_q[EntryW-1:LenW];
      rem_q  <= rd_q[LenW-1:0];
    end else if (cmd_i.step) begin
      code_q <= code_q >> step_k;
      rem_q  <= rem_after;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      cnt_q  <= '0;
    end else begin
      pend_q <= pend_d;
      cnt_q  <= cnt_d;
    end
  end

  // output register
  logic                        out_valid_q, out_valid_d;
  logic [hcte_pkg::ByteW-1:0]  out_byte_q;
  logic                        last_q;
  logic                        error_q;
  logic                        out_load;
  logic                        out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign out_load    = (cmd_i.step && fill) || cmd_i.emit_error || cmd_i.flush;
  assign out_valid_d = out_load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step && fill) begin
      out_byte_q <= acc;
      // no further byte can fill once fewer than eight bits remain
      last_q     <= (7'(rem_after) < 7'd8);
      error_q    <= 1'b0;
    end else if (cmd_i.emit_error) begin
      out_byte_q <= '0;
      last_q     <= 1'b1;
      error_q    <= 1'b1;
    end else if (cmd_i.flush) begin
      out_byte_q <= flush_byte;
      last_q     <= 1'b1;
      error_q    <= 1'b0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = out_byte_q;
  assign last_of_run_o = last_q;
  assign error_o       = error_q;

  assign status_o.out_free   = out_free;
  assign status_o.entry_ok   = entry_ok_q;
  assign status_o.pend_empty = (cnt_q == '0);
  assign status_o.step_done  = (7'(rem_q) <= 7'(space));

endmodule

>>> tb/sv/tb_top.sv
module tb_top;

  localparam logic [hcte_pkg::OpW-1:0] OP_UNUSED = 2'd3;
  localparam int RAND_ITEMS  = 380;
  localparam int HOLD_AT     = 120;  // long receiver hold-off starts here
  localparam int HOLD_CYCLES = 300;
  localparam int PAUSE_AT    = 280;  // sender waits for the pipe to drain here
  localparam int DRAIN_WAIT  = 16;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [hcte_pkg::ByteW-1:0] data;
    logic                       last;
    logic                       err;
  } pack_res_t;

  // typed = 1: n copies of data/err expected, last on the final one
  typedef struct packed {
    logic [hcte_pkg::OpW-1:0]     op;
    logic [hcte_pkg::SymbolW-1:0] sym;
    logic [hcte_pkg::CodeInW-1:0] code;
    logic [hcte_pkg::LenInW-1:0]  len;
    logic                         typed;
    logic [2:0]                   n;
    logic [hcte_pkg::ByteW-1:0]   data;
    logic                         err;
  } stim_row_t;

  localparam int DIR_N = 26;
  localparam stim_row_t DIR_ROWS [DIR_N] = '{
    // table empty
    '{hcte_pkg::OP_ENCODE, 8'd0,   32'h0000_0000, 6'd0,  1'b1, 3'd1, 8'h00, 1'b1},
    // nothing pending
    '{hcte_pkg::OP_FLUSH,  8'd0,   32'h0000_0000, 6'd0,  1'b1, 3'd0, 8'h00, 1'b0},
    '{OP_UNUSED,           8'hFF,  32'hFFFF_FFFF, 6'h3F, 1'b1, 3'd0, 8'h00, 1'b0},
    '{hcte_pkg::OP_WRITE,  8'd0,   32'hFFFF_FFFF, 6'd32, 1'b1, 3'd0, 8'h00, 1'b0},
    '{hcte_pkg::OP_ENCODE, 8'd0,   32'h0000_0000, 6'd0,  1'b1, 3'd4, 8'hFF, 1'b0},
    '{hcte_pkg::OP_WRITE,  8'd255, 32'h0000_00A5, 6'd8,  1'b1, 3'd0, 8'h00, 1'b0},
    '{hcte_pkg::OP_ENCODE, 8'd255, 32'h0000_0000, 6'd0,  1'b1, 3'd1, 8'hA5, 1'b0},
    '{hcte_pkg::OP_WRITE,  8'd1,   32'h0000_0005, 6'd3,  1'b1, 3'd0, 8'h00, 1'b0},
    // stays pending
    '{hcte_pkg::OP_ENCODE, 8'd1,   32'h0000_0000, 6'd0,  1'b1, 3'd0, 8'h00, 1'b0},
    '{hcte_pkg::OP_FLUSH,  8'd0,   32'h0000_0000, 6'd0,  1'b1, 3'd1, 8'hA0, 1'b0},
    '{hcte_pkg::OP_FLUSH,  8'd0,   32'h0000_0000, 6'd0,  1'b1, 3'd0, 8'h00, 1'b0},
    // saturates
    '{hcte_pkg::OP_WRITE,  8'd2,   32'hFFFF_FFFF, 6'd63, 1'b1, 3'd0, 8'h00, 1'b0},
    '{hcte_pkg::OP_ENCODE, 8'd1,   32'h0000_0000, 6'd0,  1'b1, 3'd0, 8'h00, 1'b0},
    '{hcte_pkg::OP_ENCODE, 8'd2,   32'h0000_0000, 6'd0,  1'b0, 3'd0, 8'h00, 1'b0},
    '{hcte_pkg::OP_ENCODE, 8'd2,   32'h0000_0000, 6'd0,  1'b0, 3'd0, 8'h00, 1'b0},
    '{hcte_pkg::OP_WRITE,  8'd3,   32'h0000_0000, 6'd1,  1'b1, 3'd0, 8'h00, 1'b0},
    '{hcte_pkg::OP_ENCODE, 8'd3,   32'h0000_0000, 6'd0,  1'b0, 3'd0, 8'h00, 1'b0},
    // invalidate
    '{hcte_pkg::OP_WRITE,  8'd1,   32'hFFFF_FFFF, 6'd0,  1'b1, 3'd0, 8'h00, 1'b0},
    '{hcte_pkg::OP_ENCODE, 8'd1,   32'h0000_0000, 6'd0,  1'b1, 3'd1, 8'h00, 1'b1},
    '{hcte_pkg::OP_WRITE,  8'd4,   32'h1234_5678, 6'd40, 1'b1, 3'd0, 8'h00, 1'b0},
    '{hcte_pkg::OP_ENCODE, 8'd4,   32'h0000_0000, 6'd0,  1'b0, 3'd0, 8'h00, 1'b0},
    // high bits dropped
    '{hcte_pkg::OP_WRITE,  8'd5,   32'hDEAD_BEEF, 6'd5,  1'b1, 3'd0, 8'h00, 1'b0},
    '{hcte_pkg::OP_ENCODE, 8'd5,   32'h0000_0000, 6'd0,  1'b0, 3'd0, 8'h00, 1'b0},
    '{hcte_pkg::OP_FLUSH,  8'd0,   32'h0000_0000, 6'd0,  1'b0, 3'd0, 8'h00, 1'b0},
    '{hcte_pkg::OP_WRITE,  8'd128, 32'h8000_0001, 6'd16, 1'b1, 3'd0, 8'h00, 1'b0},
    '{hcte_pkg::OP_ENCODE, 8'd128, 32'h0000_0000, 6'd0,  1'b0, 3'd0, 8'h00, 1'b0}
  };

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          in_valid_i;
  logic                          in_ready_o;
  logic [hcte_pkg::OpW-1:0]      op_i;
  logic [hcte_pkg::SymbolW-1:0]  symbol_i;
  logic [hcte_pkg::CodeInW-1:0]  code_bits_i;
  logic [hcte_pkg::LenInW-1:0]   code_length_i;
  logic                          out_valid_o;
  logic                          out_ready_i;
  logic [hcte_pkg::ByteW-1:0]    out_byte_o;
  logic                          last_of_run_o;
  logic                          error_o;

  // predictor state
  logic [hcte_pkg::CodeInW-1:0] code_tab [hcte_pkg::SymbolCountDef];
  logic [hcte_pkg::LenInW-1:0]  len_tab  [hcte_pkg::SymbolCountDef];
  logic                         ok_tab   [hcte_pkg::SymbolCountDef];
  logic [hcte_pkg::PendW-1:0]   pend_bits;
  logic [hcte_pkg::CntW-1:0]    pend_cnt;
  pack_res_t                    step_res [4];
  int                           step_n;

  pack_res_t packed_out_q [$];

  int  mismatches    = 0;
  int  items_sent    = 0;
  int  bytes_checked = 0;
  int  err_results   = 0;
  int  cycles        = 0;
  int  burst_left    = 0;
  bit  long_hold_req = 1'b0;

  huffman_code_table_encoder DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .op_i          (op_i),
    .symbol_i      (symbol_i),
    .code_bits_i   (code_bits_i),
    .code_length_i (code_length_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_byte_o    (out_byte_o),
    .last_of_run_o (last_of_run_o),
    .error_o       (error_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d bytes still owed", cycles, packed_out_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic note_mismatch(input string msg);
    mismatches++;
    $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  // One transaction through the table and packer; results land in step_res.
  function automatic void pack_step(input logic [hcte_pkg::OpW-1:0] op,
                                    input logic [hcte_pkg::SymbolW-1:0] sym,
                                    input logic [hcte_pkg::CodeInW-1:0] code,
                                    input logic [hcte_pkg::LenInW-1:0] len);
    logic [hcte_pkg::ByteW-1:0] acc;
    int cnt;
    int clen;
    step_n = 0;
    case (op)
      hcte_pkg::OP_WRITE: begin
        if (len == '0) begin
          ok_tab[sym] = 1'b0;
        end else begin
          clen = (len > hcte_pkg::MaxCodeBitsDef) ? hcte_pkg::MaxCodeBitsDef : int'(len);
          code_tab[sym] = (clen == 32) ? code : (code & ((32'd1 << clen) - 32'd1));
          len_tab[sym]  = clen[hcte_pkg::LenInW-1:0];
          ok_tab[sym]   = 1'b1;
        end
      end
      hcte_pkg::OP_ENCODE: begin
        if (!ok_tab[sym]) begin
          step_res[0] = '{8'h00, 1'b1, 1'b1};
          step_n = 1;
        end else begin
          acc = {1'b0, pend_bits};
          cnt = int'(pend_cnt);
          for (int i = 0; i < int'(len_tab[sym]); i++) begin
            acc = {acc[hcte_pkg::ByteW-2:0], code_tab[sym][i]};
            cnt++;
            if (cnt == 8) begin
              step_res[step_n] = '{acc, 1'b0, 1'b0};
              step_n++;
              acc = '0;
              cnt = 0;
            end
          end
          if (step_n > 0) step_res[step_n-1].last = 1'b1;
          pend_bits = acc[hcte_pkg::PendW-1:0];
          pend_cnt  = cnt[hcte_pkg::CntW-1:0];
        end
      end
      hcte_pkg::OP_FLUSH: begin
        if (pend_cnt != '0) begin
          acc = {1'b0, pend_bits} << (8 - int'(pend_cnt));
          step_res[0] = '{acc, 1'b1, 1'b0};
          step_n = 1;
          pend_bits = '0;
          pend_cnt  = '0;
        end
      end
      default: ;
    endcase
  endfunction

  task automatic issue_item(input stim_row_t row);
    int gap;
    @(negedge clk_i);
    in_valid_i    <= 1'b1;
    op_i          <= row.op;
    symbol_i      <= row.sym;
    code_bits_i   <= row.code;
    code_length_i <= row.len;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
    pack_step(row.op, row.sym, row.code, row.len);
    if (row.typed) begin
      for (int i = 0; i < int'(row.n); i++)
        packed_out_q.push_back('{row.data, (i == int'(row.n) - 1), row.err});
    end else begin
      for (int i = 0; i < step_n; i++) packed_out_q.push_back(step_res[i]);
    end
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 24);
      gap = $urandom_range(1, 6);
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  function automatic logic [hcte_pkg::SymbolW-1:0] pick_symbol();
    if ($urandom_range(0, 4) != 0) return hcte_pkg::SymbolW'($urandom_range(0, 15));
    return hcte_pkg::SymbolW'($urandom_range(0, 255));
  endfunction

  // receiver: stall pattern in random modes, plus one long hold-off on request
  initial begin
    int mode;
    int left;
    int hold_cnt;
    mode = 0;
    left = 0;
    hold_cnt = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_cnt = HOLD_CYCLES;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ready_i <= 1'b0;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 2);
          left = $urandom_range(16, 80);
        end
        left--;
        case (mode)
          0:       out_ready_i <= 1'b1;
          1:       out_ready_i <= ($urandom_range(0, 3) != 0);
          default: out_ready_i <= ($urandom_range(0, 9) < 3);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    pack_res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      bytes_checked++;
      if (packed_out_q.size() == 0) begin
        note_mismatch($sformatf("unexpected result byte %h last %b err %b",
                                out_byte_o, last_of_run_o, error_o));
      end else begin
        want = packed_out_q.pop_front();
        if (want.err) err_results++;
        if (out_byte_o !== want.data)
          note_mismatch($sformatf("out_byte %h, want %h", out_byte_o, want.data));
        if (last_of_run_o !== want.last)
          note_mismatch($sformatf("last_of_run %b, want %b", last_of_run_o, want.last));
        if (error_o !== want.err)
          note_mismatch($sformatf("error %b, want %b", error_o, want.err));
      end
    end
  end

  initial begin
    stim_row_t row;
    int  k;
    int  w;
    bit  hold_done;
    bit  pause_done;
    for (int i = 0; i < hcte_pkg::SymbolCountDef; i++) begin
      ok_tab[i]   = 1'b0;
      code_tab[i] = '0;
      len_tab[i]  = '0;
    end
    pend_bits = '0;
    pend_cnt  = '0;
    in_valid_i    = 1'b0;
    op_i          = hcte_pkg::OP_WRITE;
    symbol_i      = '0;
    code_bits_i   = '0;
    code_length_i = '0;
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int i = 0; i < DIR_N; i++) issue_item(DIR_ROWS[i]);

    k = 0;
    hold_done = 1'b0;
    pause_done = 1'b0;
    while (k < RAND_ITEMS) begin
      if (k == HOLD_AT && !hold_done) begin
        hold_done = 1'b1;
        long_hold_req = 1'b1;
        burst_left = 80;  // keep offering while the output is blocked
      end
      if (k == PAUSE_AT && !pause_done) begin
        pause_done = 1'b1;
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        while (packed_out_q.size() != 0) @(posedge clk_i);
      end
      row = '0;
      row.code = $urandom;
      w = $urandom_range(0, 99);
      if (k < 16) begin
        row.op  = hcte_pkg::OP_WRITE;
        row.sym = hcte_pkg::SymbolW'(k);
        row.len = hcte_pkg::LenInW'($urandom_range(1, 12));
      end else if (w < 18) begin
        row.op  = hcte_pkg::OP_WRITE;
        row.sym = pick_symbol();
        w = $urandom_range(0, 19);
        if (w == 0)     row.len = '0;
        else if (w < 3) row.len = hcte_pkg::LenInW'($urandom_range(33, 63));
        else if (w < 6) row.len = hcte_pkg::LenInW'($urandom_range(13, 32));
        else            row.len = hcte_pkg::LenInW'($urandom_range(1, 12));
      end else if (w < 88) begin
        row.op  = hcte_pkg::OP_ENCODE;
        row.sym = pick_symbol();
        row.len = hcte_pkg::LenInW'($urandom_range(0, 63));
      end else if (w < 97) begin
        row.op  = hcte_pkg::OP_FLUSH;
        row.sym = hcte_pkg::SymbolW'($urandom_range(0, 255));
      end else begin
        row.op  = OP_UNUSED;
        row.sym = hcte_pkg::SymbolW'($urandom_range(0, 255));
        row.len = hcte_pkg::LenInW'($urandom_range(0, 63));
      end
      issue_item(row);
      if (row.op != OP_UNUSED) k++;
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (packed_out_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("Sent %0d transactions (%0d directed), checked %0d output bytes",
             items_sent, DIR_N, bytes_checked);
    $display("incl. %0d missing-entry results; %0d mismatches", err_results, mismatches);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/hcte_pkg.sv
rtl/hcte_ctrl.sv
rtl/hcte_datapath.sv
rtl/huffman_code_table_encoder.sv
tb/sv/tb_top.sv
